// ----- design/ptw_pkg.sv -----
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared types for the permutation tree walker: item modes, controller
// states, datapath micro-ops and the status word fed back to the controller.
// ----------------------------------------------------------------------------
package ptw_pkg;

   typedef enum logic [2:0] {
      MODE_LOAD_INTERVAL = 3'd0,
      MODE_LOAD_ROOT     = 3'd1,
      MODE_MARK          = 3'd2,
      MODE_SET_DIR       = 3'd3,
      MODE_SELECT        = 3'd4,
      MODE_DECODE        = 3'd5
   } mode_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_SCAN,
      S_PROBE,
      S_CHECK,
      S_ADV,
      S_UP1,
      S_UP2,
      S_CP_RD,
      S_CP_WR,
      S_BR_FIN,
      S_OUT_FOUND,
      S_OUT_EXH,
      S_DEC_CHK,
      S_DEC_WR,
      S_FILL_RD,
      S_FILL_WR,
      S_EMIT
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_SCAN_STEP,
      OP_PROBE,
      OP_CLR_IDX,
      OP_ADVANCE,
      OP_UP1,
      OP_UP2,
      OP_CP_RD,
      OP_CP_WR,
      OP_BR_FIN,
      OP_OUT_FOUND,
      OP_OUT_EXH,
      OP_DEC_RD,
      OP_DEC_WR,
      OP_FILL_RD,
      OP_FILL_WR,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic scan_lt;
      logic scan_gt;
      logic idx_top;
      logic p_out;
      logic pruned;
      logic depth_zero;
      logic leaf;
      logic lvl_done;
      logic cp_last;
      logic fill_last;
      logic out_free;
   } status_type;

endpackage

// ----- design/permutation_tree_walker.sv -----
// ----------------------------------------------------------------------------
// permutation_tree_walker
// Load, mark and direction items are taken in the idle state. A select, per
// walk step, compares position against end digit by digit, then probes and
// advances or backs up; a branch copies the row with a read and a write per
// entry (one matrix memory port). A decode builds the schedule, then emits N items.
// One item is in work at a time. Synchronous reset restores the empty interval.
// ----------------------------------------------------------------------------
module permutation_tree_walker #(
   parameter int N = 20
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [2:0]        req_mode,
   input  logic [4:0]        req_index,
   input  logic [5:0]        req_pos_value,
   input  logic [4:0]        req_end_value,
   input  logic [4:0]        req_job_value,
   input  logic              req_dir_value,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_found,
   output logic [4:0]        rsp_depth,
   output logic [4:0]        rsp_slot,
   output logic [4:0]        rsp_job,
   output logic signed [5:0] rsp_limit_low,
   output logic [5:0]        rsp_limit_high,
   output logic              rsp_last
);

   ptw_pkg::cmd_type    cmd;
   ptw_pkg::status_type st;

   ptw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_stall (req_stall),
      .st        (st),
      .cmd       (cmd)
   );

   ptw_datapath #(.N(N)) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_mode       (req_mode),
      .req_index      (req_index),
      .req_pos_value  (req_pos_value),
      .req_end_value  (req_end_value),
      .req_job_value  (req_job_value),
      .req_dir_value  (req_dir_value),
      .st             (st),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_found      (rsp_found),
      .rsp_depth      (rsp_depth),
      .rsp_slot       (rsp_slot),
      .rsp_job        (rsp_job),
      .rsp_limit_low  (rsp_limit_low),
      .rsp_limit_high (rsp_limit_high),
      .rsp_last       (rsp_last)
   );

endmodule

// ----- design/ptw_ctrl.sv -----
// ----------------------------------------------------------------------------
// ptw_ctrl
// Sequencer for the tree walker: runs the select walk, the branch row copy
// and the decode schedule build and readout as datapath micro-ops.
// ----------------------------------------------------------------------------
module ptw_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [2:0]          req_mode,
   output logic                req_stall,
   input  ptw_pkg::status_type st,
   output ptw_pkg::cmd_type    cmd
);

   ptw_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptw_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.op    = ptw_pkg::OP_NONE;
      req_stall = 1'b1;
      case (state_ff)
         ptw_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.op = ptw_pkg::OP_ACCEPT;
               if (ptw_pkg::mode_type'(req_mode) == ptw_pkg::MODE_SELECT) begin
                  state_in = ptw_pkg::S_SCAN;
               end else if (ptw_pkg::mode_type'(req_mode) == ptw_pkg::MODE_DECODE) begin
                  state_in = ptw_pkg::S_DEC_CHK;
               end
            end
         end
         ptw_pkg::S_SCAN: begin
            // lexicographic position <= end check, one digit a cycle
            cmd.op = ptw_pkg::OP_SCAN_STEP;
            if (st.scan_lt) begin
               state_in = ptw_pkg::S_PROBE;
            end else if (st.scan_gt) begin
               state_in = ptw_pkg::S_OUT_EXH;
            end else if (st.idx_top) begin
               state_in = ptw_pkg::S_PROBE;
            end
         end
         ptw_pkg::S_PROBE: begin
            cmd.op = ptw_pkg::OP_PROBE;
            state_in = st.p_out ? ptw_pkg::S_UP1 : ptw_pkg::S_CHECK;
         end
         ptw_pkg::S_CHECK: begin
            cmd.op = ptw_pkg::OP_CLR_IDX;
            if (st.pruned) begin
               state_in = ptw_pkg::S_ADV;
            end else if (st.leaf) begin
               state_in = ptw_pkg::S_OUT_FOUND;
            end else begin
               state_in = ptw_pkg::S_CP_RD;
            end
         end
         ptw_pkg::S_ADV: begin
            cmd.op = ptw_pkg::OP_ADVANCE;
            state_in = ptw_pkg::S_SCAN;
         end
         ptw_pkg::S_UP1: begin
            cmd.op = ptw_pkg::OP_UP1;
            state_in = st.depth_zero ? ptw_pkg::S_SCAN : ptw_pkg::S_UP2;
         end
         ptw_pkg::S_UP2: begin
            cmd.op = ptw_pkg::OP_UP2;
            state_in = ptw_pkg::S_SCAN;
         end
         ptw_pkg::S_CP_RD: begin
            cmd.op = ptw_pkg::OP_CP_RD;
            state_in = ptw_pkg::S_CP_WR;
         end
         ptw_pkg::S_CP_WR: begin
            cmd.op = ptw_pkg::OP_CP_WR;
            state_in = st.cp_last ? ptw_pkg::S_BR_FIN : ptw_pkg::S_CP_RD;
         end
         ptw_pkg::S_BR_FIN: begin
            cmd.op = ptw_pkg::OP_BR_FIN;
            state_in = ptw_pkg::S_OUT_FOUND;
         end
         ptw_pkg::S_OUT_FOUND: begin
            if (st.out_free) begin
               cmd.op = ptw_pkg::OP_OUT_FOUND;
               state_in = ptw_pkg::S_IDLE;
            end
         end
         ptw_pkg::S_OUT_EXH: begin
            if (st.out_free) begin
               cmd.op = ptw_pkg::OP_OUT_EXH;
               state_in = ptw_pkg::S_IDLE;
            end
         end
         ptw_pkg::S_DEC_CHK: begin
            if (st.lvl_done) begin
               cmd.op = ptw_pkg::OP_CLR_IDX;
               state_in = ptw_pkg::S_FILL_RD;
            end else begin
               cmd.op = ptw_pkg::OP_DEC_RD;
               state_in = ptw_pkg::S_DEC_WR;
            end
         end
         ptw_pkg::S_DEC_WR: begin
            cmd.op = ptw_pkg::OP_DEC_WR;
            state_in = ptw_pkg::S_DEC_CHK;
         end
         ptw_pkg::S_FILL_RD: begin
            cmd.op = ptw_pkg::OP_FILL_RD;
            state_in = ptw_pkg::S_FILL_WR;
         end
         ptw_pkg::S_FILL_WR: begin
            cmd.op = ptw_pkg::OP_FILL_WR;
            state_in = st.fill_last ? ptw_pkg::S_EMIT : ptw_pkg::S_FILL_RD;
         end
         ptw_pkg::S_EMIT: begin
            // one schedule slot per free result register, slot N-1 ends the run
            if (st.out_free) begin
               cmd.op = ptw_pkg::OP_EMIT;
               if (st.idx_top) begin
                  state_in = ptw_pkg::S_IDLE;
               end
            end
         end
         default: begin
            state_in = ptw_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// ----- design/ptw_datapath.sv -----
// ----------------------------------------------------------------------------
// ptw_datapath
// Position, end and direction vectors, the job and pruned-flag matrices, the
// decode schedule buffer and the result register.
// ----------------------------------------------------------------------------
module ptw_datapath #(
   parameter int N = 20
) (
   input  logic                clock,
   input  logic                reset,
   input  ptw_pkg::cmd_type    cmd,
   input  logic [2:0]          req_mode,
   input  logic [4:0]          req_index,
   input  logic [5:0]          req_pos_value,
   input  logic [4:0]          req_end_value,
   input  logic [4:0]          req_job_value,
   input  logic                req_dir_value,
   output ptw_pkg::status_type st,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_found,
   output logic [4:0]          rsp_depth,
   output logic [4:0]          rsp_slot,
   output logic [4:0]          rsp_job,
   output logic signed [5:0]   rsp_limit_low,
   output logic [5:0]          rsp_limit_high,
   output logic                rsp_last
);

   localparam int COLW = (N > 1) ? $clog2(N) : 1;
   localparam int AW = $clog2(N * N);
   localparam logic [5:0] N6 = 6'(N);
   localparam logic [AW-1:0] NA = AW'(N);

   logic [COLW-1:0] depth_ff, depth_in, idx_ff, idx_in;
   logic [5:0] p_ff, p_in;
   logic signed [5:0] lo_ff, lo_in;
   logic [5:0] hi_ff, hi_in;
   logic dir_pend_ff, dir_pend_in;
   logic job_zero_ff, job_zero_in, prune_zero_ff, prune_zero_in;
   logic [4:0] job_rd_ff;
   logic prune_rd_ff;

   logic [5:0] pos_ff [N];
   logic [4:0] end_ff [N];
   logic dir_ff [N];
   logic job_v0_ff [N];
   logic prune_v0_ff [N];
   logic [4:0] sched_ff [N];
   logic [4:0] job_mem [N*N];
   logic prune_mem [N*N];

   logic rsp_valid_ff, rsp_found_ff, rsp_last_ff;
   logic [4:0] rsp_depth_ff, rsp_slot_ff, rsp_job_ff;
   logic signed [5:0] rsp_limit_low_ff;
   logic [5:0] rsp_limit_high_ff;

   logic pos_we, end_we, dir_we, job_we, prune_we, sched_we, jv0_set, pv0_set;
   logic [COLW-1:0] pos_wa, dir_wa, sched_wa, v0_wa, pos_ra, icol, src;
   logic [5:0] pos_wd, pos_rd, rem6;
   logic [4:0] end_rd, job_val, job_wd, sched_wd;
   logic dir_wd, prune_wd, prune_val, in_range, out_load, out_free;
   logic [AW-1:0] job_wa, job_ra, prune_wa, prune_ra;
   logic signed [5:0] lo_p1;
   logic [5:0] hi_m1, fsum;

   function automatic logic [AW-1:0] cell_addr(input logic [COLW-1:0] row,
                                                input logic [COLW-1:0] col);
      cell_addr = AW'(AW'(row) * NA + AW'(col));
   endfunction

   assign pos_ra = (cmd.op == ptw_pkg::OP_SCAN_STEP || cmd.op == ptw_pkg::OP_DEC_RD)
                   ? idx_ff : depth_ff;
   assign pos_rd = pos_ff[pos_ra];
   assign end_rd = end_ff[idx_ff];
   assign rem6 = N6 - 6'(depth_ff);
   assign job_val = job_zero_ff ? 5'd0 : job_rd_ff;
   assign prune_val = !prune_zero_ff && prune_rd_ff;
   assign in_range = {1'b0, req_index} < N6;
   assign icol = req_index[COLW-1:0];
   assign src = (6'(idx_ff) < p_ff) ? idx_ff : idx_ff + 1'b1;
   assign lo_p1 = lo_ff + 6'sd1;
   assign hi_m1 = hi_ff - 6'd1;
   assign fsum = 6'(lo_ff) + 6'd1 + 6'(idx_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign st.scan_lt = pos_rd < {1'b0, end_rd};
   assign st.scan_gt = pos_rd > {1'b0, end_rd};
   assign st.idx_top = 6'(idx_ff) == N6 - 6'd1;
   assign st.p_out = pos_rd >= rem6;
   assign st.pruned = prune_val;
   assign st.depth_zero = depth_ff == '0;
   assign st.leaf = 6'(depth_ff) == N6 - 6'd1;
   assign st.lvl_done = idx_ff == depth_ff;
   assign st.cp_last = 6'(idx_ff) == rem6 - 6'd2;
   assign st.fill_last = 6'(idx_ff) == rem6 - 6'd1;
   assign st.out_free = out_free;

   always_comb begin
      depth_in = depth_ff;
      idx_in = idx_ff;
      p_in = p_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      dir_pend_in = dir_pend_ff;
      job_zero_in = job_zero_ff;
      prune_zero_in = prune_zero_ff;
      pos_we = 1'b0;
      pos_wa = icol;
      pos_wd = req_pos_value;
      end_we = 1'b0;
      dir_we = 1'b0;
      dir_wa = depth_ff;
      dir_wd = req_dir_value;
      job_we = 1'b0;
      job_wa = cell_addr('0, icol);
      job_wd = req_job_value;
      job_ra = cell_addr(depth_ff, idx_ff);
      prune_we = 1'b0;
      prune_wa = cell_addr('0, icol);
      prune_wd = 1'b0;
      prune_ra = cell_addr(depth_ff, pos_rd[COLW-1:0]);
      sched_we = 1'b0;
      sched_wa = idx_ff;
      sched_wd = job_val;
      jv0_set = 1'b0;
      pv0_set = 1'b0;
      v0_wa = icol;
      out_load = 1'b0;
      case (cmd.op)
         ptw_pkg::OP_ACCEPT: begin
            idx_in = '0;
            lo_in = -6'sd1;
            hi_in = N6;
            case (ptw_pkg::mode_type'(req_mode))
               ptw_pkg::MODE_LOAD_INTERVAL: begin
                  pos_we = in_range;
                  end_we = in_range;
               end
               ptw_pkg::MODE_LOAD_ROOT: begin
                  job_we = in_range;
                  prune_we = in_range;
                  jv0_set = in_range;
                  pv0_set = in_range;
               end
               ptw_pkg::MODE_MARK: begin
                  prune_we = in_range;
                  prune_wa = cell_addr(depth_ff, icol);
                  prune_wd = 1'b1;
                  pv0_set = in_range && (depth_ff == '0);
               end
               ptw_pkg::MODE_SET_DIR: begin
                  dir_we = 1'b1;
               end
               default: begin
               end
            endcase
         end
         ptw_pkg::OP_SCAN_STEP: begin
            idx_in = idx_ff + 1'b1;
         end
         ptw_pkg::OP_PROBE: begin
            p_in = pos_rd;
            prune_zero_in = (depth_ff == '0) && !prune_v0_ff[pos_rd[COLW-1:0]];
         end
         ptw_pkg::OP_CLR_IDX: begin
            idx_in = '0;
         end
         ptw_pkg::OP_ADVANCE: begin
            pos_we = 1'b1;
            pos_wa = depth_ff;
            pos_wd = p_ff + 6'd1;
            idx_in = '0;
         end
         ptw_pkg::OP_UP1: begin
            pos_we = 1'b1;
            pos_wa = depth_ff;
            idx_in = '0;
            if (depth_ff == '0) begin
               pos_wd = pos_rd + 6'd1;
            end else begin
               pos_wd = 6'd0;
               depth_in = depth_ff - 1'b1;
            end
         end
         ptw_pkg::OP_UP2: begin
            // prune the parent cell unless the stored digit is stale
            prune_we = pos_rd < N6;
            prune_wa = cell_addr(depth_ff, pos_rd[COLW-1:0]);
            prune_wd = 1'b1;
            v0_wa = pos_rd[COLW-1:0];
            pv0_set = (pos_rd < N6) && (depth_ff == '0);
            idx_in = '0;
         end
         ptw_pkg::OP_CP_RD: begin
            job_ra = cell_addr(depth_ff, src);
            job_zero_in = (depth_ff == '0) && !job_v0_ff[src];
         end
         ptw_pkg::OP_CP_WR: begin
            job_we = 1'b1;
            job_wa = cell_addr(depth_ff + 1'b1, idx_ff);
            job_wd = job_val;
            prune_we = 1'b1;
            prune_wa = cell_addr(depth_ff + 1'b1, idx_ff);
            prune_wd = 1'b0;
            idx_in = idx_ff + 1'b1;
         end
         ptw_pkg::OP_BR_FIN: begin
            depth_in = depth_ff + 1'b1;
            pos_we = 1'b1;
            pos_wa = depth_ff + 1'b1;
            pos_wd = 6'd0;
            dir_we = 1'b1;
            dir_wa = depth_ff + 1'b1;
            dir_wd = 1'b0;
         end
         ptw_pkg::OP_OUT_FOUND, ptw_pkg::OP_OUT_EXH: begin
            out_load = 1'b1;
         end
         ptw_pkg::OP_DEC_RD: begin
            job_ra = cell_addr(idx_ff, pos_rd[COLW-1:0]);
            // cells beyond a row's live width were never written and read zero
            job_zero_in = (pos_rd >= N6) ||
                          ((idx_ff == '0) ? !job_v0_ff[pos_rd[COLW-1:0]]
                                          : (pos_rd >= N6 - 6'(idx_ff)));
            dir_pend_in = dir_ff[idx_ff];
         end
         ptw_pkg::OP_DEC_WR: begin
            sched_we = 1'b1;
            if (!dir_pend_ff) begin
               sched_wa = lo_p1[COLW-1:0];
               lo_in = lo_p1;
            end else begin
               sched_wa = hi_m1[COLW-1:0];
               hi_in = hi_m1;
            end
            idx_in = idx_ff + 1'b1;
         end
         ptw_pkg::OP_FILL_RD: begin
            job_ra = cell_addr(depth_ff, idx_ff);
            job_zero_in = (depth_ff == '0) && !job_v0_ff[idx_ff];
         end
         ptw_pkg::OP_FILL_WR: begin
            sched_we = 1'b1;
            sched_wa = fsum[COLW-1:0];
            idx_in = st.fill_last ? '0 : idx_ff + 1'b1;
         end
         ptw_pkg::OP_EMIT: begin
            out_load = 1'b1;
            idx_in = idx_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
         idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < N; i++) begin
            pos_ff[i] <= (i == 0) ? N6 : 6'd0;
            end_ff[i] <= 5'd0;
            dir_ff[i] <= 1'b0;
            job_v0_ff[i] <= 1'b0;
            prune_v0_ff[i] <= 1'b0;
         end
      end else begin
         depth_ff <= depth_in;
         idx_ff <= idx_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (pos_we) begin
            pos_ff[pos_wa] <= pos_wd;
         end
         if (end_we) begin
            end_ff[pos_wa] <= req_end_value;
         end
         if (dir_we) begin
            dir_ff[dir_wa] <= dir_wd;
         end
         if (jv0_set) begin
            job_v0_ff[v0_wa] <= 1'b1;
         end
         if (pv0_set) begin
            prune_v0_ff[v0_wa] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      dir_pend_ff <= dir_pend_in;
      job_zero_ff <= job_zero_in;
      prune_zero_ff <= prune_zero_in;
      if (sched_we) begin
         sched_ff[sched_wa] <= sched_wd;
      end
      if (out_load) begin
         rsp_found_ff <= cmd.op == ptw_pkg::OP_OUT_FOUND;
         rsp_depth_ff <= 5'(depth_ff);
         if (cmd.op == ptw_pkg::OP_EMIT) begin
            rsp_slot_ff <= 5'(idx_ff);
            rsp_job_ff <= sched_ff[idx_ff];
            rsp_limit_low_ff <= lo_ff;
            rsp_limit_high_ff <= hi_ff;
            rsp_last_ff <= st.idx_top;
         end else begin
            rsp_slot_ff <= 5'd0;
            rsp_job_ff <= 5'd0;
            rsp_limit_low_ff <= 6'sd0;
            rsp_limit_high_ff <= 6'd0;
            rsp_last_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (job_we) begin
         job_mem[job_wa] <= job_wd;
      end
      job_rd_ff <= job_mem[job_ra];
   end

   always_ff @(posedge clock) begin
      if (prune_we) begin
         prune_mem[prune_wa] <= prune_wd;
      end
      prune_rd_ff <= prune_mem[prune_ra];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = rsp_found_ff;
   assign rsp_depth = rsp_depth_ff;
   assign rsp_slot = rsp_slot_ff;
   assign rsp_job = rsp_job_ff;
   assign rsp_limit_low = rsp_limit_low_ff;
   assign rsp_limit_high = rsp_limit_high_ff;
   assign rsp_last = rsp_last_ff;

`ifndef SYNTHESIS
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      6'(depth_ff) < N6)
      else $error("depth beyond tree");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> out_free)
      else $error("result register overwritten");
   a_branch_depth: assert property (@(posedge clock) disable iff (reset)
      cmd.op == ptw_pkg::OP_BR_FIN |=> depth_ff == $past(depth_ff) + 1'b1)
      else $error("branch did not descend");
`endif

endmodule

// ----- tb/sv/permutation_tree_walker_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// permutation_tree_walker_tb
// Drives load, mark, direction, select and decode items through the walker
// with bursty input and a patterned output stall. A local model of the search
// tree predicts every select and decode result, and each result is checked
// field by field in order.
// ----------------------------------------------------------------------------
module permutation_tree_walker_tb;

   localparam int N = 20;

   typedef struct {
      logic [2:0] mode;
      logic [4:0] index;
      logic [5:0] pos_value;
      logic [4:0] end_value;
      logic [4:0] job_value;
      logic       dir_value;
   } walk_item_type;

   typedef struct {
      logic              found;
      logic [4:0]        depth;
      logic [4:0]        slot;
      logic [4:0]        job;
      logic signed [5:0] limit_low;
      logic [5:0]        limit_high;
      logic              last;
   } walk_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [2:0]        req_mode = '0;
   logic [4:0]        req_index = '0;
   logic [5:0]        req_pos_value = '0;
   logic [4:0]        req_end_value = '0;
   logic [4:0]        req_job_value = '0;
   logic              req_dir_value = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_found;
   logic [4:0]        rsp_depth;
   logic [4:0]        rsp_slot;
   logic [4:0]        rsp_job;
   logic signed [5:0] rsp_limit_low;
   logic [5:0]        rsp_limit_high;
   logic              rsp_last;

   permutation_tree_walker #(.N(N)) DUT (.*);

   // local copy of the search tree
   logic [7:0] pos_digit [N];
   logic [7:0] end_digit [N];
   logic       dir_bit [N];
   logic [4:0] cell_job [N*N];
   logic       cell_pruned [N*N];
   int         cur_depth;

   walk_item_type   pending_q[$];
   walk_result_type results_due[$];
   int              mismatches = 0;
   bit              gen_done = 0;

   function automatic bit within_interval();
      for (int i = 0; i < N; i++) begin
         if (pos_digit[i] < end_digit[i]) return 1;
         if (pos_digit[i] > end_digit[i]) return 0;
      end
      return 1;
   endfunction

   function automatic void back_up();
      int p;
      if (cur_depth > 0) begin
         pos_digit[cur_depth] = 8'd0;
         cur_depth--;
         p = pos_digit[cur_depth];
         if (p < N) cell_pruned[cur_depth*N + p] = 1;
      end else begin
         pos_digit[0] = pos_digit[0] + 8'd1;
      end
   endfunction

   function automatic void branch_child();
      int child, col, src;
      child = cur_depth + 1;
      col = pos_digit[cur_depth];
      for (int i = 0; i + child < N; i++) begin
         src = (i < col) ? i : i + 1;
         cell_job[child*N + i] = cell_job[cur_depth*N + src];
         cell_pruned[child*N + i] = 0;
      end
      cur_depth = child;
      pos_digit[child] = 8'd0;
      dir_bit[child] = 0;
   endfunction

   function automatic bit select_next();
      int p;
      while (within_interval()) begin
         p = pos_digit[cur_depth];
         if (p >= N - cur_depth) back_up();
         else if (cell_pruned[cur_depth*N + p])
            pos_digit[cur_depth] = pos_digit[cur_depth] + 8'd1;
         else begin
            if (cur_depth + 1 < N) branch_child();
            return 1;
         end
      end
      return 0;
   endfunction

   function automatic void predict_walk(walk_item_type it);
      walk_result_type r;
      logic [4:0]      sched [N];
      int              lo, hi, p, s;
      logic [4:0]      j;
      case (it.mode)
         ptw_pkg::MODE_LOAD_INTERVAL: if (it.index < N) begin
            pos_digit[it.index] = 8'(it.pos_value);
            end_digit[it.index] = 8'(it.end_value);
         end
         ptw_pkg::MODE_LOAD_ROOT: if (it.index < N) begin
            cell_job[it.index] = it.job_value;
            cell_pruned[it.index] = 0;
         end
         ptw_pkg::MODE_MARK: if (it.index < N) cell_pruned[cur_depth*N + it.index] = 1;
         ptw_pkg::MODE_SET_DIR: dir_bit[cur_depth] = it.dir_value;
         ptw_pkg::MODE_SELECT: begin
            r = '{default: '0};
            r.found = select_next();
            r.depth = 5'(cur_depth);
            results_due.push_back(r);
         end
         ptw_pkg::MODE_DECODE: begin
            lo = -1;
            hi = N;
            foreach (sched[k]) sched[k] = 5'd0;
            for (int l = 0; l < cur_depth; l++) begin
               p = pos_digit[l];
               j = (p < N) ? cell_job[l*N + p] : 5'd0;
               if (dir_bit[l] == 0) begin
                  lo++;
                  if (lo >= 0 && lo < N) sched[lo] = j;
               end else begin
                  hi--;
                  if (hi >= 0 && hi < N) sched[hi] = j;
               end
            end
            for (int l = 0; l + cur_depth < N; l++) begin
               s = lo + 1 + l;
               if (s >= 0 && s < N) sched[s] = cell_job[cur_depth*N + l];
            end
            for (int k = 0; k < N; k++) begin
               r.found = 0;
               r.depth = 5'(cur_depth);
               r.slot = 5'(k);
               r.job = sched[k];
               r.limit_low = 6'(lo);
               r.limit_high = 6'(hi);
               r.last = (k == N - 1);
               results_due.push_back(r);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void add_item(logic [2:0] m, int idx, int pv);
      walk_item_type it;
      it.mode = m;
      it.index = 5'(idx);
      it.pos_value = 6'(pv);
      it.end_value = 5'($urandom);
      it.job_value = 5'($urandom);
      it.dir_value = 1'($urandom);
      pending_q.push_back(it);
   endfunction

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #200_000_000;
      $display("permutation_tree_walker_tb: errors");
      $finish;
   end

   // driver: bursts of items with random gaps
   int burst_left = 0, gap_left = 0;
   always @(posedge clock) begin
      walk_item_type it;
      logic          take;
      if (reset) begin
         req_valid <= 0;
      end else begin
         take = !req_valid || !req_stall;
         if (req_valid && !req_stall) begin
            it.mode = req_mode; it.index = req_index; it.pos_value = req_pos_value;
            it.end_value = req_end_value; it.job_value = req_job_value;
            it.dir_value = req_dir_value;
            predict_walk(it);
         end
         if (take) begin
            if (burst_left == 0 && gap_left == 0) begin
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
               burst_left = $urandom_range(1, 12);
            end
            if (gap_left > 0 || pending_q.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req_valid <= 0;
            end else begin
               it = pending_q.pop_front();
               burst_left--;
               req_valid <= 1;
               req_mode <= it.mode; req_index <= it.index; req_pos_value <= it.pos_value;
               req_end_value <= it.end_value; req_job_value <= it.job_value;
               req_dir_value <= it.dir_value;
            end
         end
      end
   end

   // result stall: quiet stretches, then a random duty pattern
   int stall_phase = 0;
   always @(posedge clock) begin
      stall_phase <= (stall_phase + 1) % 300;
      rsp_stall <= (stall_phase >= 150) && ($urandom_range(0, 2) == 0);
   end

   always @(posedge clock) begin
      walk_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (results_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result item: depth %0d", rsp_depth);
         end else begin
            e = results_due.pop_front();
            if (rsp_found !== e.found || rsp_depth !== e.depth || rsp_slot !== e.slot ||
                rsp_job !== e.job || rsp_limit_low !== e.limit_low ||
                rsp_limit_high !== e.limit_high || rsp_last !== e.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch exp f%0d d%0d s%0d j%0d lo%0d hi%0d l%0d",
                            " got f%0d d%0d s%0d j%0d lo%0d hi%0d l%0d"},
                           e.found, e.depth, e.slot, e.job, e.limit_low, e.limit_high,
                           e.last, rsp_found, rsp_depth, rsp_slot, rsp_job,
                           rsp_limit_low, rsp_limit_high, rsp_last);
            end
         end
      end
   end

   initial begin
      int r;
      foreach (pos_digit[i]) begin
         pos_digit[i] = 8'd0; end_digit[i] = 8'd0; dir_bit[i] = 0;
      end
      foreach (cell_job[i]) begin
         cell_job[i] = 5'd0; cell_pruned[i] = 0;
      end
      pos_digit[0] = 8'(N);
      cur_depth = 0;

      // directed: empty interval, then a small walk through every mode
      add_item(ptw_pkg::MODE_SELECT, 0, 0);
      add_item(ptw_pkg::MODE_DECODE, 0, 0);
      add_item(ptw_pkg::MODE_LOAD_INTERVAL, 0, 0);
      pending_q[$].end_value = 5'd31;
      add_item(ptw_pkg::MODE_LOAD_INTERVAL, 31, 32);         // out of range depth
      add_item(ptw_pkg::MODE_LOAD_ROOT, 0, 0);  pending_q[$].job_value = 5'd31;
      add_item(ptw_pkg::MODE_LOAD_ROOT, N - 1, 0); pending_q[$].job_value = 5'd0;
      add_item(ptw_pkg::MODE_LOAD_ROOT, 25, 0);              // ignored
      add_item(ptw_pkg::MODE_MARK, 0, 0);
      add_item(ptw_pkg::MODE_MARK, 0, 0);                    // already pruned
      add_item(ptw_pkg::MODE_MARK, 31, 0);
      add_item(ptw_pkg::MODE_SET_DIR, 0, 0); pending_q[$].dir_value = 1;
      add_item(ptw_pkg::MODE_SELECT, 0, 0);
      add_item(ptw_pkg::MODE_SET_DIR, 0, 0); pending_q[$].dir_value = 0;
      add_item(ptw_pkg::MODE_SELECT, 0, 0);
      add_item(ptw_pkg::MODE_DECODE, 0, 0);
      add_item(3'd6, 5, 1);
      add_item(3'd7, 31, 63);
      add_item(ptw_pkg::MODE_LOAD_INTERVAL, 1, 32);          // stale parent digit
      pending_q[$].end_value = 5'd0;
      add_item(ptw_pkg::MODE_DECODE, 0, 0);
      add_item(ptw_pkg::MODE_SELECT, 0, 0);
      add_item(ptw_pkg::MODE_DECODE, 0, 0);

      while (pending_q.size() < 190) begin
         // new interval and root row, then walk on it
         for (int d = 0; d < 3; d++) begin
            add_item(ptw_pkg::MODE_LOAD_INTERVAL, d, 0);
            pending_q[$].end_value = (d == 0) ? 5'($urandom_range(0, N - 1))
                                              : 5'($urandom);
         end
         for (int c = 0; c < N; c++)
            if ($urandom_range(0, 1)) add_item(ptw_pkg::MODE_LOAD_ROOT, c, 0);
         for (int k = 0; k < 25; k++) begin
            r = $urandom_range(0, 99);
            if (r < 40) add_item(ptw_pkg::MODE_SELECT, $urandom, $urandom);
            else if (r < 62) add_item(ptw_pkg::MODE_MARK, $urandom_range(0, 22), $urandom);
            else if (r < 72) add_item(ptw_pkg::MODE_SET_DIR, $urandom, $urandom);
            else if (r < 85) add_item(ptw_pkg::MODE_DECODE, $urandom, $urandom);
            else if (r < 90) add_item(3'($urandom_range(6, 7)), $urandom, $urandom);
            else if (r < 95) add_item(ptw_pkg::MODE_LOAD_INTERVAL, $urandom_range(0, 31),
                                      $urandom_range(0, 32));
            else add_item(ptw_pkg::MODE_LOAD_ROOT, $urandom, $urandom);
         end
      end
      gen_done = 1;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 0;
      wait (gen_done);
      while (pending_q.size() != 0 || req_valid || results_due.size() != 0)
         @(posedge clock);
      repeat (1000) @(posedge clock);
      if (mismatches == 0 && results_due.size() == 0)
         $display("permutation_tree_walker_tb: clean");
      else
         $display("permutation_tree_walker_tb: errors");
      $finish;
   end

endmodule
